// ----- hdl/static_arithmetic_decoder_top_defines.svh -----
// Assertion macros shared by the decoder's checker.
`ifndef STATIC_ARITHMETIC_DECODER_TOP_DEFINES_SVH
`define STATIC_ARITHMETIC_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, suspended during reset.
`define SAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, sampled on clk, suspended during reset.
`define SAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ----- hdl/sad_pkg.sv -----
// Types and constants of the static arithmetic decoder.
package sad_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_START  = 2'd1,
    MODE_DECODE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  entry_index;
    logic [13:0] entry_cum;
    logic [7:0]  entry_symbol;
    logic [15:0] bit_window;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       is_end;
    logic [4:0] bits_used;
    logic       range_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SEARCH,
    ST_SEARCH_RD,
    ST_RENORM
  } state_t;

  typedef enum logic [1:0] {
    SEL_FREQ,
    SEL_HI,
    SEL_LO
  } sel_t;

  localparam int CUM_W     = 14;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 16;
  localparam int SPAN_W    = 17;
  localparam int PROD_W    = 31;
  localparam int CNT_W     = 9;
  localparam int DIV_CNT_W = 5;
  localparam int STEP_W    = 5;

  localparam logic [CODE_W-1:0] HALF_PT      = 16'h8000;
  localparam logic [CODE_W-1:0] QUARTER_PT   = 16'h4000;
  localparam logic [CODE_W-1:0] THREE_QTR_PT = 16'hC000;
  localparam logic [CODE_W-1:0] TOP_VALUE    = 16'hFFFF;
  localparam logic [STEP_W-1:0] MAX_STEPS    = 5'd16;

endpackage

// ----- hdl/sad_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sad_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sad_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sad_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sad_pkg::PROD_W-1:0] dividend,
  input  logic [sad_pkg::SPAN_W-1:0] divisor,
  output logic                      done,
  output logic [sad_pkg::PROD_W-1:0] quotient
);

  logic [sad_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          done_r;
  logic [sad_pkg::SPAN_W-1:0]    rem_r;
  logic [sad_pkg::SPAN_W-1:0]    dsr_r;
  logic [sad_pkg::PROD_W-1:0]    quo_r;
  logic [sad_pkg::SPAN_W:0]      shifted;
  logic                          fits;

  assign shifted = {rem_r, quo_r[sad_pkg::PROD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= sad_pkg::DIV_CNT_W'(sad_pkg::PROD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == sad_pkg::DIV_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? sad_pkg::SPAN_W'(shifted - {1'b0, dsr_r})
                    : shifted[sad_pkg::SPAN_W-1:0];
      quo_r <= {quo_r[sad_pkg::PROD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/static_arithmetic_decoder_top.sv -----
// Static-model arithmetic decoder: sequencer around a shared multiplier and divider.
// Load, start and unused-mode transactions leave busy low; the result strobes next cycle.
// A decode reads the total, then makes three passes of multiply, divider launch, 31 quotient
// bits and done, with the table search after the first and renormalisation steps after the
// last; a zero scaled frequency skips the divider in the first pass.
// Results cannot be stalled; synchronous reset sets the full interval, zero code and count.
module static_arithmetic_decoder_top #(
  parameter int MAX_SYMBOLS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sad_pkg::in_item_t   in_data,
  output logic                out_valid,
  output sad_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data
);

  localparam int IDX_W = $clog2(MAX_SYMBOLS);
  localparam int WORD_W = sad_pkg::CUM_W + sad_pkg::SYM_W;
  localparam logic [sad_pkg::CNT_W-1:0] MAX_N = sad_pkg::CNT_W'(MAX_SYMBOLS);

  sad_pkg::state_t state_r, state_nxt;
  sad_pkg::sel_t   sel_r, sel_nxt;

  logic [sad_pkg::CNT_W-1:0]  cfg_r;
  logic [sad_pkg::CODE_W-1:0] low_r, low_nxt, high_r, high_nxt, code_r, code_nxt;
  logic [sad_pkg::SPAN_W-1:0] diff_r, diff_nxt, off_r, off_nxt;
  logic [sad_pkg::CUM_W-1:0]  total_r, total_nxt, tprev_r, tprev_nxt, tcur_r, tcur_nxt;
  logic [sad_pkg::PROD_W-1:0] prod_r, prod_nxt, freq_r, freq_nxt, q1_r, q1_nxt;
  logic [sad_pkg::CNT_W-1:0]  j_r, j_nxt;
  logic [sad_pkg::SYM_W-1:0]  sym_r, sym_nxt;
  logic [sad_pkg::CODE_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, val_r, val_nxt, win_r, win_nxt;
  logic [sad_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic                       rerr_r, rerr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sad_pkg::out_item_t         out_r, out_nxt;

  logic [sad_pkg::CNT_W-1:0]  n_act, n_less, j_less;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_raddr;
  logic [WORD_W-1:0]          ram_rdata;
  logic [sad_pkg::CUM_W-1:0]  rd_cum;
  logic [sad_pkg::SYM_W-1:0]  rd_sym;
  logic [sad_pkg::SPAN_W-1:0] mul_a, div_dsr;
  logic [sad_pkg::CUM_W-1:0]  mul_b;
  logic [sad_pkg::PROD_W-1:0] mul_p, div_dvd, div_q;
  logic                       div_start, div_done;
  logic [sad_pkg::CODE_W-1:0] win_rev, sub_m;
  logic                       accept;

  assign accept = start && (state_r == sad_pkg::ST_IDLE);
  assign busy   = state_r != sad_pkg::ST_IDLE;

  assign n_act  = (cfg_r > MAX_N) ? MAX_N : cfg_r;
  assign n_less = n_act - 1'b1;
  assign j_less = j_r - 1'b1;

  assign ram_we    = accept && (in_data.mode == sad_pkg::MODE_LOAD) &&
                     ({1'b0, in_data.entry_index} < MAX_N);
  assign ram_raddr = (state_r == sad_pkg::ST_IDLE) ? n_less[IDX_W-1:0] : j_less[IDX_W-1:0];
  assign rd_cum    = ram_rdata[sad_pkg::CUM_W-1:0];
  assign rd_sym    = ram_rdata[WORD_W-1:sad_pkg::CUM_W];

  sad_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.entry_index[IDX_W-1:0]),
    .wdata ({in_data.entry_symbol, in_data.entry_cum}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One multiplier serves all three products of a decode.
  assign mul_a = (sel_r == sad_pkg::SEL_FREQ) ? off_r : diff_r;
  assign mul_b = (sel_r == sad_pkg::SEL_FREQ) ? total_r :
                 (sel_r == sad_pkg::SEL_HI)   ? tcur_r  : tprev_r;
  assign mul_p = mul_a * mul_b;

  assign div_dvd = (sel_r == sad_pkg::SEL_FREQ) ? prod_r - 1'b1 : prod_r;
  assign div_dsr = (sel_r == sad_pkg::SEL_FREQ) ? diff_r : {3'b000, total_r};

  sad_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    for (int b = 0; b < sad_pkg::CODE_W; b++) begin
      win_rev[sad_pkg::CODE_W-1-b] = in_data.bit_window[b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sad_pkg::ST_IDLE;
      cfg_r       <= '0;
      low_r       <= '0;
      high_r      <= sad_pkg::TOP_VALUE;
      code_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    diff_r  <= diff_nxt;
    off_r   <= off_nxt;
    total_r <= total_nxt;
    tprev_r <= tprev_nxt;
    tcur_r  <= tcur_nxt;
    prod_r  <= prod_nxt;
    freq_r  <= freq_nxt;
    q1_r    <= q1_nxt;
    j_r     <= j_nxt;
    sym_r   <= sym_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    val_r   <= val_nxt;
    win_r   <= win_nxt;
    steps_r <= steps_nxt;
    rerr_r  <= rerr_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    code_nxt      = code_r;
    diff_nxt      = diff_r;
    off_nxt       = off_r;
    total_nxt     = total_r;
    tprev_nxt     = tprev_r;
    tcur_nxt      = tcur_r;
    prod_nxt      = prod_r;
    freq_nxt      = freq_r;
    q1_nxt        = q1_r;
    j_nxt         = j_r;
    sym_nxt       = sym_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    val_nxt       = val_r;
    win_nxt       = win_r;
    steps_nxt     = steps_r;
    rerr_nxt      = rerr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_start     = 1'b0;
    sub_m         = '0;

    unique case (state_r)
      sad_pkg::ST_IDLE: begin
        if (start) begin
          out_nxt = '0;
          unique case (in_data.mode)
            sad_pkg::MODE_START: begin
              code_nxt          = win_rev;
              low_nxt           = '0;
              high_nxt          = sad_pkg::TOP_VALUE;
              out_nxt.bits_used = sad_pkg::MAX_STEPS;
              out_valid_nxt     = 1'b1;
            end
            sad_pkg::MODE_DECODE: begin
              diff_nxt  = sad_pkg::SPAN_W'({1'b0, high_r} - {1'b0, low_r} + 1'b1);
              off_nxt   = sad_pkg::SPAN_W'({1'b0, code_r} - {1'b0, low_r} + 1'b1);
              win_nxt   = in_data.bit_window;
              state_nxt = sad_pkg::ST_TOTAL;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      sad_pkg::ST_TOTAL: begin
        total_nxt = (n_act == '0 || rd_cum == '0) ? sad_pkg::CUM_W'(1) : rd_cum;
        j_nxt     = sad_pkg::CNT_W'(1);
        tprev_nxt = '0;
        tcur_nxt  = sad_pkg::CUM_W'(1);
        sel_nxt   = sad_pkg::SEL_FREQ;
        state_nxt = sad_pkg::ST_MUL;
      end
      sad_pkg::ST_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = sad_pkg::ST_DIV_GO;
      end
      sad_pkg::ST_DIV_GO: begin
        // A degenerate interval or zero numerator gives a scaled frequency of zero.
        if (sel_r == sad_pkg::SEL_FREQ && (diff_r == '0 || prod_r == '0)) begin
          freq_nxt  = '0;
          state_nxt = sad_pkg::ST_SEARCH;
        end else begin
          div_start = 1'b1;
          state_nxt = sad_pkg::ST_DIV_WAIT;
        end
      end
      sad_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          unique case (sel_r)
            sad_pkg::SEL_FREQ: begin
              freq_nxt  = div_q;
              state_nxt = sad_pkg::ST_SEARCH;
            end
            sad_pkg::SEL_HI: begin
              q1_nxt    = div_q;
              sel_nxt   = sad_pkg::SEL_LO;
              state_nxt = sad_pkg::ST_MUL;
            end
            default: begin
              // The new high is below the new low exactly when q1 does not exceed q0.
              rerr_nxt  = q1_r <= div_q;
              hi_nxt    = low_r + q1_r[sad_pkg::CODE_W-1:0] - 1'b1;
              lo_nxt    = low_r + div_q[sad_pkg::CODE_W-1:0];
              val_nxt   = code_r;
              steps_nxt = '0;
              state_nxt = sad_pkg::ST_RENORM;
            end
          endcase
        end
      end
      sad_pkg::ST_SEARCH: begin
        if (j_r <= n_act && {17'd0, tcur_r} <= freq_r) begin
          tprev_nxt = tcur_r;
          j_nxt     = j_r + 1'b1;
          state_nxt = sad_pkg::ST_SEARCH_RD;
        end else begin
          sel_nxt   = sad_pkg::SEL_HI;
          state_nxt = sad_pkg::ST_MUL;
        end
      end
      sad_pkg::ST_SEARCH_RD: begin
        tcur_nxt  = rd_cum;
        sym_nxt   = rd_sym;
        state_nxt = sad_pkg::ST_SEARCH;
      end
      sad_pkg::ST_RENORM: begin
        if (steps_r == sad_pkg::MAX_STEPS ||
            !(hi_r < sad_pkg::HALF_PT || lo_r >= sad_pkg::HALF_PT ||
              (lo_r >= sad_pkg::QUARTER_PT && hi_r < sad_pkg::THREE_QTR_PT))) begin
          low_nxt              = lo_r;
          high_nxt             = hi_r;
          code_nxt             = val_r;
          out_nxt.is_end       = j_r == sad_pkg::CNT_W'(1);
          out_nxt.symbol_valid = j_r != sad_pkg::CNT_W'(1);
          out_nxt.symbol       = (j_r == sad_pkg::CNT_W'(1)) ? '0 : sym_r;
          out_nxt.bits_used    = steps_r;
          out_nxt.range_error  = rerr_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = sad_pkg::ST_IDLE;
        end else begin
          if (hi_r < sad_pkg::HALF_PT) begin
            sub_m = '0;
          end else if (lo_r >= sad_pkg::HALF_PT) begin
            sub_m = sad_pkg::HALF_PT;
          end else begin
            sub_m = sad_pkg::QUARTER_PT;
          end
          lo_nxt    = {lo_r[sad_pkg::CODE_W-2:0] - sub_m[sad_pkg::CODE_W-2:0], 1'b0};
          hi_nxt    = {hi_r[sad_pkg::CODE_W-2:0] - sub_m[sad_pkg::CODE_W-2:0], 1'b1};
          val_nxt   = {val_r[sad_pkg::CODE_W-2:0] - sub_m[sad_pkg::CODE_W-2:0],
                       win_r[steps_r[3:0]]};
          steps_nxt = steps_r + 1'b1;
        end
      end
      default: begin
        state_nxt = sad_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/sad_checker.sv -----
// Port-level checker for the static arithmetic decoder, bound to the top level.
`include "static_arithmetic_decoder_top_defines.svh"

module sad_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input sad_pkg::in_item_t  in_data,
  input logic               out_valid,
  input sad_pkg::out_item_t out_data
);

  // A decode transaction keeps the block busy; every other one answers at once.
  `SAD_ASSERT_NEXT(a_decode_busy, start && !busy && in_data.mode == sad_pkg::MODE_DECODE, busy)
  `SAD_ASSERT_NEXT(a_quick_result, start && !busy && in_data.mode != sad_pkg::MODE_DECODE, out_valid && !busy)
  `SAD_ASSERT_NOW(a_end_not_data, out_valid && out_data.is_end, !out_data.symbol_valid && out_data.symbol == 8'd0)
  `SAD_ASSERT_NOW(a_bits_bound, out_valid, out_data.bits_used <= 5'd16)

endmodule

bind static_arithmetic_decoder_top sad_checker u_sad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- tb/tb_static_arithmetic_decoder_top.sv -----
// Self-checking testbench for the static arithmetic decoder: model loads, starts and decodes.
`timescale 1ns / 100ps

module tb_static_arithmetic_decoder_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 3000000;

  class decode_scoreboard;
    logic [8:0]         sym_count;
    logic [15:0]        low_q, high_q, code_q;
    logic [13:0]        cum_tab [256];
    logic [7:0]         sym_tab [256];
    sad_pkg::out_item_t expected_results [$];
    int                 errors;

    function new();
      sym_count = '0;
      low_q = '0;
      high_q = sad_pkg::TOP_VALUE;
      code_q = '0;
      errors = 0;
      foreach (cum_tab[i]) begin
        cum_tab[i] = '0;
        sym_tab[i] = '0;
      end
    endfunction

    function void set_count(logic [8:0] v);
      sym_count = v;
    endfunction

    // Position 0 is the bottom of the range and position 1 the end-of-stream marker.
    function longint cum_at(int p);
      if (p == 0) return 0;
      if (p == 1) return 1;
      return cum_tab[(p - 2) & 255];
    endfunction

    function void note_input(sad_pkg::in_item_t it);
      sad_pkg::out_item_t r;
      int n, j, steps;
      longint total, diff, off, num, freq, nh, nl;
      logic [15:0] lo, hi, val;
      r = '0;
      case (it.mode)
        sad_pkg::MODE_LOAD: begin
          cum_tab[it.entry_index] = it.entry_cum;
          sym_tab[it.entry_index] = it.entry_symbol;
        end
        sad_pkg::MODE_START: begin
          for (int b = 0; b < 16; b++) code_q[15 - b] = it.bit_window[b];
          low_q = '0;
          high_q = sad_pkg::TOP_VALUE;
          r.bits_used = 5'd16;
        end
        sad_pkg::MODE_DECODE: begin
          n = (sym_count > 256) ? 256 : int'(sym_count);
          total = cum_at(n + 1);
          if (total == 0) total = 1;
          diff = (longint'(high_q) - longint'(low_q) + 1) & 'h1FFFF;
          off = (longint'(code_q) - longint'(low_q) + 1) & 'h1FFFF;
          num = off * total;
          freq = 0;
          if (diff != 0 && num != 0) freq = (num - 1) / diff;
          j = 1;
          while (j < n + 1 && cum_at(j) <= freq) j++;
          nh = longint'(low_q) + cum_at(j) * diff / total - 1;
          nl = longint'(low_q) + cum_at(j - 1) * diff / total;
          r.range_error = (nh < nl);
          hi = nh[15:0];
          lo = nl[15:0];
          val = code_q;
          steps = 0;
          while (steps < 16) begin
            if (hi < sad_pkg::HALF_PT) begin
            end else if (lo >= sad_pkg::HALF_PT) begin
              lo -= sad_pkg::HALF_PT;
              hi -= sad_pkg::HALF_PT;
              val -= sad_pkg::HALF_PT;
            end else if (lo >= sad_pkg::QUARTER_PT && hi < sad_pkg::THREE_QTR_PT) begin
              lo -= sad_pkg::QUARTER_PT;
              hi -= sad_pkg::QUARTER_PT;
              val -= sad_pkg::QUARTER_PT;
            end else begin
              break;
            end
            lo = lo << 1;
            hi = {hi[14:0], 1'b1};
            val = {val[14:0], it.bit_window[steps]};
            steps++;
          end
          low_q = lo;
          high_q = hi;
          code_q = val;
          r.bits_used = steps[4:0];
          if (j == 1) begin
            r.is_end = 1'b1;
          end else begin
            r.symbol = sym_tab[(j - 2) & 255];
            r.symbol_valid = 1'b1;
          end
        end
        default: ;
      endcase
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(sad_pkg::out_item_t got);
      sad_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
          got.is_end !== want.is_end || got.bits_used !== want.bits_used ||
          got.range_error !== want.range_error) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk, rst_n, start, busy, out_valid, cfg_we;
  logic [8:0]         cfg_data;
  sad_pkg::in_item_t  in_data;
  sad_pkg::out_item_t out_data;

  decode_scoreboard sb = new();
  int items_sent = 0;
  int cycles = 0;
  bit no_gaps = 0;

  static_arithmetic_decoder_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Leaves start high so that back-to-back transactions need no toggle.
  task automatic send(logic [1:0] mode, logic [7:0] idx, logic [13:0] cum,
                      logic [7:0] sym, logic [15:0] win);
    sad_pkg::in_item_t it;
    it.mode = mode;
    it.entry_index = idx;
    it.entry_cum = cum;
    it.entry_symbol = sym;
    it.bit_window = win;
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic pause();
    int r, g;
    r = $urandom_range(0, 99);
    g = (no_gaps || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_count(logic [8:0] v);
    start <= 1'b0;
    while (sb.expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
  endtask

  task automatic send_random(logic [1:0] mode);
    send(mode, 8'($urandom), 14'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic decode_burst(int nd);
    int r;
    send_random(sad_pkg::MODE_START);
    pause();
    for (int i = 0; i < nd; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_random(MODE_UNUSED);
      else if (r < 5) send_random(sad_pkg::MODE_START);
      else send_random(sad_pkg::MODE_DECODE);
      pause();
    end
  endtask

  // A well-formed table has strictly rising cumulative counts; a broken one is random.
  task automatic run_phase(logic [8:0] count, bit well_formed);
    int n, acc, step_max;
    n = (count > 256) ? 256 : int'(count);
    write_count(count);
    no_gaps = ($urandom_range(0, 3) == 0);
    acc = 1;
    step_max = (n > 0) ? 16382 / n : 1;
    if (step_max > 200 && $urandom_range(0, 1)) step_max = 200;
    for (int k = 0; k < n; k++) begin
      acc += $urandom_range(1, step_max);
      send(sad_pkg::MODE_LOAD, k[7:0], well_formed ? acc[13:0] : 14'($urandom),
           8'($urandom), 16'($urandom));
      pause();
    end
    decode_burst((n > 64) ? 6 : $urandom_range(10, 40));
  endtask

  initial begin
    int r;
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, the unused mode, an empty model and a zero total.
    write_count(9'd0);
    send(MODE_UNUSED, 8'hFF, 14'h3FFF, 8'hFF, 16'hFFFF);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'h0000);
    send(sad_pkg::MODE_START, 8'h00, 14'h0000, 8'h00, 16'h0000);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'hFFFF);
    send(sad_pkg::MODE_START, 8'hFF, 14'h3FFF, 8'hFF, 16'hFFFF);
    send(sad_pkg::MODE_DECODE, 8'hFF, 14'h3FFF, 8'hFF, 16'h0000);
    send(sad_pkg::MODE_LOAD, 8'h00, 14'h3FFF, 8'h00, 16'h0000);
    send(sad_pkg::MODE_LOAD, 8'hFF, 14'h0001, 8'hFF, 16'hFFFF);
    write_count(9'd1);
    send(sad_pkg::MODE_START, 8'h00, 14'h0000, 8'h00, 16'hFFFF);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'h5555);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'hAAAA);
    send(sad_pkg::MODE_LOAD, 8'h00, 14'h0000, 8'h7F, 16'h0000);
    send(sad_pkg::MODE_START, 8'h00, 14'h0000, 8'h00, 16'h1234);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'h0F0F);
    send(sad_pkg::MODE_DECODE, 8'h00, 14'h0000, 8'h00, 16'hF0F0);

    // Full tables, including a count beyond the table size that must saturate, then a two-entry table.
    run_phase(9'd256, 1'b1);
    run_phase(9'd511, 1'b0);
    run_phase(9'd2, 1'b1);

    while (items_sent < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) run_phase(9'($urandom_range(1, 12)), 1'b1);
      else if (r < 88) run_phase(9'($urandom_range(13, 64)), 1'b1);
      else if (r < 96) run_phase(9'($urandom_range(0, 12)), 1'b0);
      else run_phase(9'($urandom_range(200, 511)), 1'($urandom_range(0, 1)));
    end

    start <= 1'b0;
    while (sb.expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
